// ===== hdl/nwop_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwop_pkg: shared types and constants of the waveform offset planner
// item layouts, register indexes, field widths and the offset bit swap
// ----------------------------------------------------------------------------
package nwop_pkg;

  localparam int unsigned FractionWidthDef = 32;
  localparam int unsigned MaxTransfersDef  = 64;

  localparam int unsigned PosWidth   = 41;
  localparam int unsigned StepWidth  = 27;
  localparam int unsigned PhaseWidth = 16;
  localparam int unsigned CountWidth = 6;
  localparam int unsigned WordWidth  = 10;
  localparam int unsigned WholeWidth = 9;
  localparam int unsigned CfgIdxWidth = 2;

  // register indexes on the configuration port
  localparam logic [CfgIdxWidth-1:0] CfgPositionStep = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgPeriodWrap   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgPhaseStep    = 2'd2;

  // offset rearrangement constants
  localparam logic [WholeWidth-1:0] LowFieldMask  = 9'h01f;
  localparam logic [WholeWidth-1:0] HighFieldMask = 9'h1e0;
  localparam int unsigned           FieldShift    = 5;

  typedef struct packed {
    logic signed [PhaseWidth-1:0] phase_offset;
    logic [CountWidth-1:0]        transfer_count;
  } in_item_t;

  typedef struct packed {
    logic [WordWidth-1:0] word_offset;
    logic                 last_offset;
  } out_item_t;

  // low five advance bits go up, whole-word bits come down
  function automatic logic [WordWidth-1:0] swap_fields(input logic [WholeWidth-1:0] whole);
    logic [WordWidth-1:0] lo_part;
    logic [WordWidth-1:0] hi_part;
    lo_part = WordWidth'(whole & LowFieldMask) << FieldShift;
    hi_part = WordWidth'(whole & HighFieldMask) >> FieldShift;
    return lo_part | hi_part;
  endfunction

endpackage

// ===== hdl/nco_waveform_offset_planner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_waveform_offset_planner: phase-modulated waveform offset planner
// per audio sample, emits one buffer word offset for each transfer
// ----------------------------------------------------------------------------
// One sample item carries a signed phase offset and a transfer count. The
// block multiplies the phase offset by phase_step once, then for every
// transfer runs five steps through a single shared 44-bit add/subtract unit:
// add modulation to the position accumulator, wrap down, wrap up and emit
// the offset, advance by position_step, wrap the accumulator. A sample with
// transfers therefore occupies the block until its last accumulator wrap,
// longer if the result side stalls, and in_ready_o is low all that time; a
// count of zero is taken with no results and the block stays ready. Results
// leave through an output register, so one finished offset may wait while
// the next is being worked out. Configuration writes are always taken and
// must only be issued while the block is idle.
module nco_waveform_offset_planner
  import nwop_pkg::*;
#(
  parameter int unsigned FRACTION_WIDTH = FractionWidthDef,
  parameter int unsigned MAX_TRANSFERS  = MaxTransfersDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // sample items
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_item_i,
  // offset items
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              out_item_o,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [PosWidth-1:0]    cfg_data_i
);

  // working width: holds acc + modulation and every field bit position
  localparam int unsigned ProdWidth = StepWidth + 1 + PhaseWidth;
  localparam int unsigned SumWidth  = (FRACTION_WIDTH + WholeWidth > ProdWidth) ?
                                      FRACTION_WIDTH + WholeWidth : ProdWidth;
  localparam int unsigned CntWidth  = $clog2(MAX_TRANSFERS);

  // sequencer states
  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StMul     = 3'd1;
  localparam logic [2:0] StAddMod  = 3'd2;
  localparam logic [2:0] StWrapHi  = 3'd3;
  localparam logic [2:0] StWrapLo  = 3'd4;
  localparam logic [2:0] StAdv     = 3'd5;
  localparam logic [2:0] StAdvWrap = 3'd6;

  logic [2:0]                   state_q, state_d;
  logic [PosWidth-1:0]          pos_step_q;
  logic [PosWidth-1:0]          period_wrap_q;
  logic [StepWidth-1:0]         phase_step_q;
  logic [PosWidth-1:0]          acc_q, acc_d;
  logic [CntWidth-1:0]          cnt_q, cnt_d;
  logic signed [PhaseWidth-1:0] phase_q;
  logic signed [SumWidth-1:0]   mod_q;
  logic signed [SumWidth-1:0]   work_q, work_d;
  logic                         out_valid_q;
  out_item_t                    out_item_q;

  logic                         in_fire;
  logic                         emit;
  logic [CountWidth:0]          count_ext;
  logic [CountWidth:0]          count_sat;
  logic signed [ProdWidth-1:0]  product;

  // shared add/subtract unit
  logic signed [SumWidth-1:0]   op_a;
  logic signed [SumWidth-1:0]   op_b;
  logic                         op_sub;
  logic signed [SumWidth-1:0]   unit_res;
  logic                         res_pos;
  logic signed [SumWidth-1:0]   wrapped;
  logic [WholeWidth-1:0]        whole;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // count saturates below the transfer limit
  assign count_ext = {1'b0, in_item_i.transfer_count};
  assign count_sat = (count_ext >= (CountWidth+1)'(MAX_TRANSFERS)) ?
                     (CountWidth+1)'(MAX_TRANSFERS - 1) : count_ext;

  assign product = $signed({1'b0, phase_step_q}) * phase_q;

  // operand selection per step
  always_comb begin
    op_a   = work_q;
    op_b   = SumWidth'($signed({1'b0, period_wrap_q}));
    op_sub = 1'b0;
    unique case (state_q)
      StAddMod: begin
        op_a = SumWidth'($signed({1'b0, acc_q}));
        op_b = mod_q;
      end
      StWrapHi:  op_sub = 1'b1;
      StAdv: begin
        op_a = SumWidth'($signed({1'b0, acc_q}));
        op_b = SumWidth'($signed({1'b0, pos_step_q}));
      end
      StAdvWrap: op_sub = 1'b1;
      default: ;
    endcase
  end

  assign unit_res = op_sub ? (op_a - op_b) : (op_a + op_b);
  // difference strictly above zero means the minuend exceeded the wrap
  assign res_pos  = !unit_res[SumWidth-1] && (unit_res != '0);

  // upward wrap only when the sum is still negative
  assign wrapped = work_q[SumWidth-1] ? unit_res : work_q;
  assign whole   = wrapped[FRACTION_WIDTH +: WholeWidth];
  assign emit    = (state_q == StWrapLo) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    work_d  = work_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          cnt_d   = CntWidth'(count_sat);
          state_d = (count_sat == '0) ? StIdle : StMul;
        end
      end
      StMul:    state_d = StAddMod;
      StAddMod: begin
        work_d  = unit_res;
        state_d = StWrapHi;
      end
      StWrapHi: begin
        if (res_pos) begin
          work_d = unit_res;
        end
        state_d = StWrapLo;
      end
      StWrapLo: begin
        // hold here while the previous offset is still waiting
        if (emit) begin
          state_d = StAdv;
        end
      end
      StAdv: begin
        work_d  = unit_res;
        state_d = StAdvWrap;
      end
      StAdvWrap: begin
        acc_d   = res_pos ? unit_res[PosWidth-1:0] : work_q[PosWidth-1:0];
        cnt_d   = cnt_q - CntWidth'(1);
        state_d = (cnt_q == CntWidth'(1)) ? StIdle : StAddMod;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      acc_q         <= '0;
      cnt_q         <= '0;
      pos_step_q    <= '0;
      period_wrap_q <= '1;
      phase_step_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgPositionStep: pos_step_q    <= cfg_data_i;
          CfgPeriodWrap:   period_wrap_q <= cfg_data_i;
          CfgPhaseStep:    phase_step_q  <= cfg_data_i[StepWidth-1:0];
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (in_fire) begin
      phase_q <= in_item_i.phase_offset;
    end
    if (state_q == StMul) begin
      mod_q <= SumWidth'(product);
    end
    if (emit) begin
      out_item_q.word_offset <= swap_fields(whole);
      out_item_q.last_offset <= (cnt_q == CntWidth'(1));
    end
  end

  // a sample with transfers keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (count_sat != '0) |=> !in_ready_o)
    else $error("planner took a sample with transfers but stayed ready");

  // an offset is only produced while transfers remain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (cnt_q != '0))
    else $error("offset emitted with no transfers left");

  // leaving idle only happens through an accepted sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("planner went busy without a sample");

  // the final offset of a sample is followed by a return to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && (cnt_q == CntWidth'(1)) |=> ##2 in_ready_o)
    else $error("planner did not return to idle after the last offset");

endmodule

// ===== tb/sv/nco_waveform_offset_planner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_waveform_offset_planner_tb: self-checking bench for the offset planner
// drives sample items and register writes, predicts every offset item from a
// local model of the accumulator and compares each one field by field
// ----------------------------------------------------------------------------
module nco_waveform_offset_planner_tb;
  import nwop_pkg::*;

  localparam int unsigned ClkHigh      = 6;
  localparam int unsigned ClkLow       = 6;
  localparam int unsigned ResetCycles  = 8;
  // after the last offset item the block still has to advance the accumulator
  // and return to idle
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned RandomPhases = 5;
  localparam int unsigned PhaseItems   = 20;

  localparam logic [PosWidth-1:0]  PosMax  = '1;
  localparam logic [StepWidth-1:0] StepMax = '1;

  typedef enum {ReadyAlways, ReadyMostly, ReadyToggle, ReadyRarely} ready_mode_e;

  // keeps its own copy of the registers and the position accumulator and
  // holds the offset items still due from the block
  class offset_scoreboard;
    logic [PosWidth-1:0]  position_step;
    logic [PosWidth-1:0]  period_wrap;
    logic [PosWidth-1:0]  position_acc;
    logic [StepWidth-1:0] phase_step;
    out_item_t            offsets_due[$];
    int unsigned          errors;

    function new();
      position_step = '0;
      period_wrap   = '1;
      phase_step    = '0;
      position_acc  = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [PosWidth-1:0] data);
      case (idx)
        CfgPositionStep: position_step = data;
        CfgPeriodWrap:   period_wrap   = data;
        CfgPhaseStep:    phase_step    = data[StepWidth-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return offsets_due.size();
    endfunction

    function void note_sample(in_item_t s);
      longint              modulation;
      longint              sum;
      longint              wrap_l;
      logic [WholeWidth-1:0] whole;
      logic [PosWidth:0]   advanced;
      int unsigned         n;
      out_item_t           e;
      n = s.transfer_count;
      if (n >= MaxTransfersDef) n = MaxTransfersDef - 1;
      wrap_l     = longint'({23'd0, period_wrap});
      modulation = longint'({37'd0, phase_step}) * longint'($signed(s.phase_offset));
      for (int unsigned t = 0; t < n; t++) begin
        sum = longint'({23'd0, position_acc}) + modulation;
        // single wrap each way, a sum equal to the period stays
        if (sum > wrap_l) sum -= wrap_l;
        if (sum < 0) sum += wrap_l;
        whole         = WholeWidth'(sum >>> FractionWidthDef);
        e.word_offset = {whole[4:0], 1'b0, whole[8:5]};
        e.last_offset = (t + 1 == n);
        offsets_due.push_back(e);
        advanced = {1'b0, position_acc} + {1'b0, position_step};
        if (advanced > {1'b0, period_wrap}) advanced -= {1'b0, period_wrap};
        position_acc = advanced[PosWidth-1:0];
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] offset mismatch: %s", $time, what);
      errors++;
    endtask

    task check_offset(out_item_t got);
      out_item_t want;
      if (offsets_due.size() == 0) begin
        report_mismatch($sformatf("offset %0d arrived with nothing due", got.word_offset));
        return;
      end
      want = offsets_due.pop_front();
      if (got.word_offset !== want.word_offset)
        report_mismatch($sformatf("word_offset %0d, wanted %0d",
                                  got.word_offset, want.word_offset));
      if (got.last_offset !== want.last_offset)
        report_mismatch($sformatf("last_offset %0b, wanted %0b",
                                  got.last_offset, want.last_offset));
    endtask
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  in_item_t               in_item   = '0;
  logic                   in_ready;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [PosWidth-1:0]    cfg_data  = '0;
  logic                   cfg_ready;

  offset_scoreboard sb = new();
  in_item_t         sample_plan[$];
  logic             hold_wanted  = 1'b0;
  int unsigned      quiet_cycles = 0;

  always begin
    #ClkHigh clk = 1'b1;
    #ClkLow  clk = 1'b0;
  end

  nco_waveform_offset_planner uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // inputs only move on rising edges, so the falling edge shows exactly what
  // the next rising edge will take
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_offset(out_item);
  end

  // watchdog: any handshake restarts the count of quiet cycles
  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("nco_waveform_offset_planner verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: stretches of differing readiness, plus one long hold-off on
  // request so the block backs up and drops in_ready
  initial begin : receiver_pattern
    ready_mode_e mode;
    int unsigned span;
    forever begin
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        @(posedge clk) out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
      end
      mode = ready_mode_e'($urandom_range(3, 0));
      span = $urandom_range(80, 10);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          ReadyAlways: out_ready <= 1'b1;
          ReadyMostly: out_ready <= ($urandom_range(3, 0) != 0);
          ReadyToggle: out_ready <= ~out_ready;
          default:     out_ready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // called at a rising edge, returns at the edge that takes the write;
  // the caller lowers cfg_valid once the whole set is written
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [PosWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [PosWidth-1:0] step, input logic [PosWidth-1:0] wrap,
                              input logic [StepWidth-1:0] pstep);
    write_reg(CfgPositionStep, step);
    write_reg(CfgPeriodWrap, wrap);
    write_reg(CfgPhaseStep, PosWidth'(pstep));
    cfg_valid <= 1'b0;
  endtask

  // same edge discipline as write_reg: valid stays up into the next item
  task automatic offer_sample(input in_item_t s);
    in_valid <= 1'b1;
    in_item  <= s;
    do @(negedge clk); while (!in_ready);
    sb.note_sample(s);
    @(posedge clk);
  endtask

  // sender: bursts of random length, now and then a long unbroken one
  task automatic play_plan();
    int unsigned burst;
    burst = $urandom_range(12, 1);
    foreach (sample_plan[k]) begin
      offer_sample(sample_plan[k]);
      burst--;
      if (burst == 0 && k != sample_plan.size() - 1) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk);
        burst = ($urandom_range(3, 0) == 0) ? 40 : $urandom_range(12, 1);
      end
    end
    in_valid <= 1'b0;
    sample_plan.delete();
  endtask

  // quiet block: nothing due, then room for the last accumulator update
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic void queue_sample(input logic signed [PhaseWidth-1:0] ph,
                                       input int unsigned cnt);
    in_item_t s;
    s.phase_offset   = ph;
    s.transfer_count = CountWidth'(cnt);
    sample_plan.push_back(s);
  endfunction

  // mostly short counts, a few of the largest, some zero
  function automatic void queue_random_sample();
    logic [PhaseWidth-1:0] ph;
    int unsigned           pick;
    int unsigned           cnt;
    pick = $urandom_range(19, 0);
    ph   = PhaseWidth'($urandom());
    if (pick == 0) ph = 16'h8000;
    else if (pick == 1) ph = 16'h7fff;
    pick = $urandom_range(19, 0);
    if (pick < 2) cnt = 0;
    else if (pick < 3) cnt = 63;
    else if (pick < 6) cnt = $urandom_range(62, 9);
    else cnt = $urandom_range(8, 1);
    queue_sample(ph, cnt);
  endfunction

  // realistic carrier periods most of the time, extremes now and then
  task automatic program_random();
    logic [PosWidth-1:0]  wrap;
    logic [PosWidth-1:0]  step;
    logic [StepWidth-1:0] pstep;
    case ($urandom_range(5, 0))
      0:       wrap = PosMax;
      1:       wrap = PosWidth'($urandom_range(1 << 20, 1));
      default: wrap = (PosWidth'($urandom_range(511, 16)) << FractionWidthDef) |
                      PosWidth'($urandom());
    endcase
    case ($urandom_range(5, 0))
      0:       step = '0;
      1:       step = PosMax;
      default: step = PosWidth'({$urandom(), $urandom()}) % wrap;
    endcase
    case ($urandom_range(5, 0))
      0:       pstep = StepMax;
      1:       pstep = StepWidth'($urandom());
      default: pstep = StepWidth'(wrap >> PhaseWidth);
    endcase
    program_regs(step, wrap, pstep);
  endtask

  initial begin : stimulus
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: no modulation, accumulator parked at zero
    queue_sample(16'sh0000, 1);
    queue_sample(-16'sd32768, 0);
    queue_sample(16'sh7fff, 2);
    play_plan();
    settle();

    // static accumulator, modulation lands on, over and far past the period
    program_regs('0, 41'd1000 << 26, 27'd1 << 26);
    queue_sample(16'sd1000, 1);
    queue_sample(16'sd1001, 1);
    queue_sample(-16'sd1, 1);
    queue_sample(-16'sd32768, 1);
    queue_sample(16'sd32767, 1);
    queue_sample(16'sd0, 0);
    play_plan();
    settle();

    // largest step against the smallest period: accumulator overflows
    program_regs(PosMax, 41'd1, StepMax);
    queue_sample(16'sd32767, 63);
    queue_sample(-16'sd32768, 63);
    queue_sample(-16'sd1, 5);
    play_plan();
    settle();

    // zero period: the wrap steps do nothing
    program_regs((41'd5 << 32) | 41'h1234, '0, 27'h05a5a5a);
    queue_sample(16'sd12345, 10);
    queue_sample(-16'sd12345, 10);
    queue_sample(16'sd0, 63);
    play_plan();
    settle();

    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      program_random();
      // one phase runs into a long receiver hold-off
      if (phase == 2) hold_wanted = 1'b1;
      repeat (PhaseItems) queue_random_sample();
      play_plan();
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("nco_waveform_offset_planner verification clean");
    end else begin
      $display("nco_waveform_offset_planner verification failed");
    end
    $finish;
  end

endmodule
